// File: rtl/core/zzbu_pkg.sv
// shared types and constants for the zigzag bit-unpack decoder
package zzbu_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 32;
  localparam int unsigned MAX_WIDTH          = 64;
  localparam int unsigned VALUE_BITS         = 64;
  localparam int unsigned FIELD_WIDTH_BITS   = 7;
  localparam int unsigned HELD_BITS          = 6;
  localparam int unsigned CFG_INDEX_BITS     = 2;
  localparam int unsigned CFG_DATA_BITS      = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NUM_VALUES    = 2'd0,
    REG_ELEMENT_SIZE  = 2'd1,
    REG_ZIGZAG_ENABLE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ELEM_8  = 2'd0,
    ELEM_16 = 2'd1,
    ELEM_32 = 2'd2,
    ELEM_64 = 2'd3
  } elem_size_t;

endpackage

// File: rtl/core/zzbu_if.sv
// request channels of the zigzag bit-unpack decoder
interface zzbu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface zzbu_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [zzbu_pkg::VALUE_BITS-1:0] decoded_value;
  logic                                last_value;
  logic                                all_zero;
  logic                                bad_width;

  modport source (output valid, output decoded_value, output last_value,
                  output all_zero, output bad_width, input ready);
  modport sink   (input valid, input decoded_value, input last_value,
                  input all_zero, input bad_width, output ready);
endinterface

interface zzbu_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [zzbu_pkg::CFG_INDEX_BITS-1:0]    index;
  logic [zzbu_pkg::CFG_DATA_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/zzbu_finish.sv
// zigzag decode and element-size truncation with sign extension
module zzbu_finish (
  input  logic [zzbu_pkg::VALUE_BITS-1:0] raw,
  input  zzbu_pkg::elem_size_t            element_size,
  input  logic                            zigzag_enable,
  output logic [zzbu_pkg::VALUE_BITS-1:0] value
);

  logic [zzbu_pkg::VALUE_BITS-1:0] zz;

  always_comb begin
    if (zigzag_enable) begin
      zz = (raw >> 1) ^ {zzbu_pkg::VALUE_BITS{raw[0]}};
    end else begin
      zz = raw;
    end
    case (element_size)
      zzbu_pkg::ELEM_8:  value = {{56{zz[7]}}, zz[7:0]};
      zzbu_pkg::ELEM_16: value = {{48{zz[15]}}, zz[15:0]};
      zzbu_pkg::ELEM_32: value = {{32{zz[31]}}, zz[31:0]};
      default:           value = zz;
    endcase
  end

endmodule

// File: rtl/core/zigzag_bit_unpack_decoder.sv
// top level: bit-serial zigzag column decoder
// A column arrives one byte per request: a header byte holding the field width
// (0 to 64), then data bytes with values packed lsb first. A data byte is loaded
// into the byte shift register, and no new byte is taken until each of its packed
// bits has been moved into the value store by a single-bit step; the byte ends
// early when the column's last value completes, and its pad bits are dropped.
// A bit that completes a value waits while the result register is still held
// by the sink. Each completed value is zigzag-decoded (when enabled) and
// sign-extended from the element size as it enters the result register. Width
// or count zero gives one all-zero result, a width above 64 one bad-width
// result; both end the column.
module zigzag_bit_unpack_decoder #(
  parameter int unsigned COUNT_BITS = zzbu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  zzbu_byte_if.sink            data_in,
  zzbu_result_if.source        result_out,
  zzbu_cfg_if.sink             cfg
);

  typedef enum logic [1:0] {
    S_HEADER,
    S_WAIT,
    S_BITS
  } state_t;

  state_t                                   state;
  logic [zzbu_pkg::CFG_DATA_BITS-1:0]       col_count;
  zzbu_pkg::elem_size_t                     element_size;
  logic                                     zigzag_enable;

  logic [zzbu_pkg::FIELD_WIDTH_BITS-1:0]    field_width;
  logic [zzbu_pkg::VALUE_BITS-1:0]          store;
  logic [zzbu_pkg::HELD_BITS-1:0]           bits_held;
  logic [COUNT_BITS-1:0]                    values_left;
  logic [7:0]                               shreg;
  logic [2:0]                               bit_cnt;

  logic [zzbu_pkg::VALUE_BITS-1:0]          store_next;
  logic [zzbu_pkg::FIELD_WIDTH_BITS-1:0]    held_inc;
  logic [63:0]                              count_wide;
  logic [COUNT_BITS-1:0]                    count;
  logic [zzbu_pkg::VALUE_BITS-1:0]          finished;
  logic                                     out_free;
  logic                                     accept;
  logic                                     emit;
  logic                                     step;
  logic                                     is_last;
  logic                                     hdr_bad;
  logic                                     hdr_zero;
  logic                                     load_result;

  assign out_free       = !result_out.valid || result_out.ready;
  assign data_in.ready  = (state != S_BITS) && out_free;
  assign accept         = data_in.valid && data_in.ready;
  assign cfg.ready      = 1'b1;

  assign count_wide = 64'(col_count);
  assign count      = count_wide[COUNT_BITS-1:0];

  assign hdr_bad  = (data_in.data_byte > 8'(zzbu_pkg::MAX_WIDTH));
  assign hdr_zero = (data_in.data_byte == 8'd0) || (count == '0);

  // upper store bits are still clear, so setting one bit builds the value
  always_comb begin
    store_next            = store;
    store_next[bits_held] = shreg[0];
  end

  assign held_inc = {1'b0, bits_held} + 7'd1;
  assign emit     = (held_inc >= field_width);
  assign step     = (state == S_BITS) && (!emit || out_free);
  assign is_last  = (values_left == COUNT_BITS'(1));

  assign load_result = ((state == S_HEADER) && accept && (hdr_bad || hdr_zero))
                    || (step && emit);

  zzbu_finish u_finish (
    .raw           (store_next),
    .element_size  (element_size),
    .zigzag_enable (zigzag_enable),
    .value         (finished)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count     <= '0;
      element_size  <= zzbu_pkg::ELEM_64;
      zigzag_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (zzbu_pkg::reg_index_t'(cfg.index))
        zzbu_pkg::REG_NUM_VALUES:    col_count     <= cfg.data;
        zzbu_pkg::REG_ELEMENT_SIZE:  element_size  <= zzbu_pkg::elem_size_t'(cfg.data[1:0]);
        zzbu_pkg::REG_ZIGZAG_ENABLE: zigzag_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_HEADER;
      result_out.valid <= 1'b0;
      field_width      <= '0;
      store            <= '0;
      bits_held        <= '0;
      values_left      <= '0;
      shreg            <= '0;
      bit_cnt          <= '0;
    end else begin
      if (load_result) begin
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      case (state)
        S_HEADER: begin
          if (accept) begin
            store     <= '0;
            bits_held <= '0;
            if (hdr_bad) begin
              result_out.decoded_value <= '0;
              result_out.last_value    <= 1'b1;
              result_out.all_zero      <= 1'b0;
              result_out.bad_width     <= 1'b1;
            end else if (hdr_zero) begin
              result_out.decoded_value <= '0;
              result_out.last_value    <= 1'b1;
              result_out.all_zero      <= 1'b1;
              result_out.bad_width     <= 1'b0;
            end else begin
              field_width <= data_in.data_byte[zzbu_pkg::FIELD_WIDTH_BITS-1:0];
              values_left <= count;
              state       <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (accept) begin
            shreg   <= data_in.data_byte;
            bit_cnt <= '0;
            state   <= S_BITS;
          end
        end
        S_BITS: begin
          if (step) begin
            shreg   <= shreg >> 1;
            bit_cnt <= bit_cnt + 3'd1;
            if (emit) begin
              result_out.decoded_value <= finished;
              result_out.last_value    <= is_last;
              result_out.all_zero      <= 1'b0;
              result_out.bad_width     <= 1'b0;
              values_left              <= values_left - COUNT_BITS'(1);
              store                    <= '0;
              bits_held                <= '0;
              // pad bits after the column's last value are dropped
              if (is_last) begin
                state <= S_HEADER;
              end else if (bit_cnt == 3'd7) begin
                state <= S_WAIT;
              end
            end else begin
              store     <= store_next;
              bits_held <= held_inc[zzbu_pkg::HELD_BITS-1:0];
              if (bit_cnt == 3'd7) begin
                state <= S_WAIT;
              end
            end
          end
        end
        default: state <= S_HEADER;
      endcase
    end
  end

endmodule

// File: rtl/core/zzbu_checker.sv
// port-level checks for the zigzag bit-unpack decoder, bound to the top level
module zzbu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [zzbu_pkg::VALUE_BITS-1:0] decoded_value,
  input logic                            last_value,
  input logic                            all_zero,
  input logic                            bad_width
);

  // a rejected column gives a single zero marker that ends it
  a_bad_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_width) |-> (last_value && !all_zero && decoded_value == '0))
    else $error("bad-width result malformed");

  a_zero_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && all_zero) |-> (last_value && !bad_width && decoded_value == '0))
    else $error("all-zero result malformed");

  // no new request is taken while a result is stuck in the output register
  a_no_take_when_stuck: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while result stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(decoded_value) && $stable(last_value)
       && $stable(all_zero) && $stable(bad_width)))
    else $error("stalled result changed");

endmodule

bind zigzag_bit_unpack_decoder zzbu_checker u_zzbu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (data_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .decoded_value (result_out.decoded_value),
  .last_value    (result_out.last_value),
  .all_zero      (result_out.all_zero),
  .bad_width     (result_out.bad_width)
);
